// ===== src/epms_pkg.sv =====
// Shared types, codes and constants of the ECU power-mode sequencer.
package epms_pkg;

  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [15:0] MACHINE_DELAY       = 16'd10;
  localparam logic [15:0] RESET_MIN_DELAY_DEF = 16'd10;
  localparam logic [31:0] COAST_TIME_DEF      = 32'd60000;

  typedef enum logic [2:0] {
    OP_TICK        = 3'd0,
    OP_POST        = 3'd1,
    OP_ARM_RESET   = 3'd2,
    OP_ARM_BOOT    = 3'd3,
    OP_ARM_TESTER  = 3'd4,
    OP_FORCE_MODE  = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    MODE_OFF     = 3'd0,
    MODE_QUIET   = 3'd1,
    MODE_FULL    = 3'd2,
    MODE_WAKE    = 3'd3,
    MODE_MONITOR = 3'd4
  } mode_t;

  localparam logic [2:0] MODE_MAX = 3'd4;

  localparam logic [3:0] EV_NONE          = 4'd0;
  localparam logic [3:0] EV_IGN_ON        = 4'd1;
  localparam logic [3:0] EV_IGN_OFF       = 4'd2;
  localparam logic [3:0] EV_COMM_TIMEOUT  = 4'd3;
  localparam logic [3:0] EV_STOP          = 4'd4;
  localparam logic [3:0] EV_DRIVE         = 4'd5;
  localparam logic [3:0] EV_COAST_TIMEOUT = 4'd6;
  localparam logic [3:0] EV_CAN_WAKE      = 4'd7;
  localparam logic [3:0] EV_DEEPSTOP      = 4'd8;
  localparam logic [3:0] EV_SHUTDOWN      = 4'd9;

  localparam logic [2:0] ACT_NONE     = 3'd0;
  localparam logic [2:0] ACT_SLEEP    = 3'd1;
  localparam logic [2:0] ACT_SHUTDOWN = 3'd2;
  localparam logic [2:0] ACT_RESET    = 3'd3;
  localparam logic [2:0] ACT_BOOT     = 3'd4;
  localparam logic [2:0] ACT_TESTER   = 3'd5;

  localparam logic [1:0] RST_PLAIN  = 2'd0;
  localparam logic [1:0] RST_BOOT   = 2'd1;
  localparam logic [1:0] RST_TESTER = 2'd2;

  localparam logic TARGET_OFF   = 1'b0;
  localparam logic TARGET_SLEEP = 1'b1;

  localparam logic [6:0] COMM_TX_START   = 7'h01;
  localparam logic [6:0] COMM_TX_STOP    = 7'h02;
  localparam logic [6:0] COMM_ALL_STOP   = 7'h04;
  localparam logic [6:0] COMM_TO_START   = 7'h08;
  localparam logic [6:0] COMM_TO_STOP    = 7'h10;
  localparam logic [6:0] COMM_FULL       = 7'h20;
  localparam logic [6:0] COMM_NO_STANDBY = 7'h40;

  localparam logic [1:0] COAST_NONE  = 2'd0;
  localparam logic [1:0] COAST_START = 2'd1;
  localparam logic [1:0] COAST_STOP  = 2'd2;
  localparam logic [1:0] COAST_OVER  = 2'd3;

  localparam logic [1:0] IGN_NONE  = 2'd0;
  localparam logic [1:0] IGN_START = 2'd1;
  localparam logic [1:0] IGN_END   = 2'd2;

  localparam logic [1:0] DIAG_NONE  = 2'd0;
  localparam logic [1:0] DIAG_START = 2'd1;
  localparam logic [1:0] DIAG_STOP  = 2'd2;

  localparam logic [1:0] STAND_NONE    = 2'd0;
  localparam logic [1:0] STAND_FORWARD = 2'd1;
  localparam logic [1:0] STAND_START   = 2'd2;
  localparam logic [1:0] STAND_STOP    = 2'd3;

  localparam logic [1:0] REG_RESET_MIN_DELAY = 2'd0;
  localparam logic [1:0] REG_COAST_TIME      = 2'd1;
  localparam logic [1:0] REG_NO_STANDSTILL   = 2'd2;

  typedef struct packed {
    logic [6:0] comm;
    logic [1:0] coast;
    logic [1:0] ign;
    logic [1:0] diag;
    logic [1:0] stand;
    logic       load_shutdown;
    logic       load_sleep;
    logic       coast_load;
    logic       coast_clear;
  } cmd_t;

endpackage

// ===== src/epms_queue.sv =====
// Event FIFO: push (post or coast expiry) then pop on a tick, same cycle.
module epms_queue import epms_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push_en,
  input  logic [3:0] push_code,
  input  logic       pop_en,
  output logic [3:0] front,
  output logic       dropped
);

  localparam int FW = $clog2(DEPTH + 1);

  logic [3:0]    entries      [DEPTH];
  logic [3:0]    entries_next [DEPTH];
  logic [3:0]    entries_p    [DEPTH];
  logic [FW-1:0] fill;
  logic [FW-1:0] fill_next;
  logic [FW-1:0] fill_p;
  logic          push_ok;

  always_comb begin
    push_ok = push_en && (fill != FW'(DEPTH));
    dropped = push_en && (fill == FW'(DEPTH));
    for (int i = 0; i < DEPTH; i++) begin
      entries_p[i] = (push_ok && fill == FW'(i)) ? push_code : entries[i];
    end
    fill_p = fill + FW'(push_ok);
    front  = (fill_p != '0) ? entries_p[0] : EV_NONE;
    entries_next = entries_p;
    fill_next    = fill_p;
    if (pop_en && fill_p != '0) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        entries_next[i] = entries_p[i + 1];
      end
      entries_next[DEPTH-1] = EV_NONE;
      fill_next = fill_p - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else begin
      fill <= fill_next;
    end
    entries <= entries_next;
  end

`ifndef SYNTH
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FW'(DEPTH)) else $error("queue fill above depth");
  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    dropped |=> fill == FW'(DEPTH) || $past(pop_en))
    else $error("drop with free queue slot");
  a_pop_shrinks: assert property (@(posedge clk) disable iff (rst)
    pop_en && !push_en && fill != '0 |=> fill == $past(fill) - 1'b1)
    else $error("pop did not shrink queue");
`endif

endmodule

// ===== src/epms_timers.sv =====
// Power-down countdowns, coast timer and last target / reset-type registers.
module epms_timers import epms_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic [2:0]  op,
  input  logic [15:0] timeout,
  input  logic [15:0] reset_min_delay,
  input  logic [31:0] coast_time,
  input  cmd_t        cmd,
  output logic [2:0]  action,
  output logic        coast_expire,
  output logic        target_now,
  output logic [1:0]  rtype_now
);

  logic [15:0] shutdown_count, shutdown_count_next;
  logic [15:0] sleep_count, sleep_count_next;
  logic [15:0] reset_count, reset_count_next;
  logic [15:0] boot_count, boot_count_next;
  logic [15:0] tester_count, tester_count_next;
  logic [31:0] coast_count, coast_count_next;
  logic        target_reg, target_reg_next;
  logic [1:0]  reset_type_reg, reset_type_reg_next;
  logic [15:0] arm;
  logic [15:0] shutdown_dec;
  logic [15:0] sleep_dec;
  logic [31:0] coast_dec;

  always_comb begin
    shutdown_dec        = shutdown_count;
    sleep_dec           = sleep_count;
    reset_count_next    = reset_count;
    boot_count_next     = boot_count;
    tester_count_next   = tester_count;
    coast_dec           = coast_count;
    target_reg_next     = target_reg;
    reset_type_reg_next = reset_type_reg;
    action              = ACT_NONE;
    coast_expire        = 1'b0;
    arm = (timeout < reset_min_delay) ? reset_min_delay : timeout;
    if (en) begin
      unique case (op)
        OP_ARM_RESET:  reset_count_next  = arm;
        OP_ARM_BOOT:   boot_count_next   = arm;
        OP_ARM_TESTER: tester_count_next = arm;
        OP_TICK: begin
          if (shutdown_count != '0) begin
            shutdown_dec = shutdown_count - 1'b1;
            if (shutdown_count == 16'd1) begin
              action = ACT_SHUTDOWN;
              target_reg_next = TARGET_OFF;
            end
          end else if (sleep_count != '0) begin
            sleep_dec = sleep_count - 1'b1;
            if (sleep_count == 16'd1) begin
              action = ACT_SLEEP;
              target_reg_next = TARGET_SLEEP;
            end
          end else if (reset_count != '0) begin
            reset_count_next = reset_count - 1'b1;
            if (reset_count == 16'd1) begin
              action = ACT_RESET;
              reset_type_reg_next = RST_PLAIN;
            end
          end else if (boot_count != '0) begin
            boot_count_next = boot_count - 1'b1;
            if (boot_count == 16'd1) begin
              action = ACT_BOOT;
              reset_type_reg_next = RST_BOOT;
            end
          end else if (tester_count != '0) begin
            tester_count_next = tester_count - 1'b1;
            if (tester_count == 16'd1) begin
              action = ACT_TESTER;
              reset_type_reg_next = RST_TESTER;
            end
          end else if (coast_count != '0) begin
            coast_dec = coast_count - 1'b1;
            coast_expire = (coast_count == 32'd1);
          end
        end
        default: ;
      endcase
    end
  end

  // mode machine loads override the tick decrement
  always_comb begin
    shutdown_count_next = cmd.load_shutdown ? MACHINE_DELAY : shutdown_dec;
    sleep_count_next    = cmd.load_sleep ? MACHINE_DELAY : sleep_dec;
    coast_count_next    = coast_dec;
    if (cmd.coast_load)  coast_count_next = coast_time;
    if (cmd.coast_clear) coast_count_next = '0;
  end

  assign target_now = target_reg_next;
  assign rtype_now  = reset_type_reg_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      shutdown_count <= '0;
      sleep_count    <= '0;
      reset_count    <= '0;
      boot_count     <= '0;
      tester_count   <= '0;
      coast_count    <= '0;
      target_reg     <= TARGET_OFF;
      reset_type_reg <= RST_PLAIN;
    end else begin
      shutdown_count <= shutdown_count_next;
      sleep_count    <= sleep_count_next;
      reset_count    <= reset_count_next;
      boot_count     <= boot_count_next;
      tester_count   <= tester_count_next;
      coast_count    <= coast_count_next;
      target_reg     <= target_reg_next;
      reset_type_reg <= reset_type_reg_next;
    end
  end

`ifndef SYNTH
  a_one_action: assert property (@(posedge clk) disable iff (rst)
    action != ACT_NONE |-> !coast_expire) else $error("two expiries in one tick");
  a_type_legal: assert property (@(posedge clk) disable iff (rst)
    reset_type_reg != 2'd3) else $error("illegal reset type");
  a_action_tick: assert property (@(posedge clk) disable iff (rst)
    action != ACT_NONE |-> en && op == OP_TICK) else $error("action off tick");
`endif

endmodule

// ===== src/epms_mode_fsm.sv =====
// Off/quiet/full/wake/monitor mode machine and its command flags.
module epms_mode_fsm import epms_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  logic [2:0] op,
  input  logic [2:0] new_mode,
  input  logic [3:0] event_code,
  input  logic       no_standstill,
  output logic [2:0] mode_now,
  output cmd_t       cmd
);

  mode_t mode_reg, mode_reg_next;
  logic  tick;

  assign tick = en && (op == OP_TICK);

  always_comb begin
    mode_reg_next = mode_reg;
    if (en && op == OP_FORCE_MODE && new_mode <= MODE_MAX) begin
      mode_reg_next = mode_t'(new_mode);
    end else if (tick) begin
      unique case (mode_reg)
        MODE_QUIET: begin
          if (event_code == EV_IGN_ON) mode_reg_next = MODE_FULL;
          else if (event_code == EV_COMM_TIMEOUT)
            mode_reg_next = no_standstill ? MODE_OFF : MODE_MONITOR;
        end
        MODE_FULL: begin
          if (event_code == EV_IGN_OFF || event_code == EV_COMM_TIMEOUT)
            mode_reg_next = MODE_QUIET;
        end
        MODE_WAKE, MODE_MONITOR: begin
          if (event_code == EV_CAN_WAKE) mode_reg_next = MODE_QUIET;
          else if (event_code == EV_DEEPSTOP || event_code == EV_SHUTDOWN)
            mode_reg_next = MODE_OFF;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    cmd = '0;
    if (tick) begin
      unique case (mode_reg)
        MODE_QUIET: begin
          if (event_code == EV_IGN_ON) begin
            cmd.comm  = COMM_TX_START | COMM_TO_START;
            cmd.diag  = DIAG_START;
            cmd.ign   = IGN_START;
            cmd.stand = no_standstill ? STAND_NONE : STAND_FORWARD;
          end else if (event_code == EV_COMM_TIMEOUT) begin
            if (no_standstill) begin
              cmd.comm = COMM_TO_STOP | COMM_ALL_STOP;
              cmd.load_shutdown = 1'b1;
            end else begin
              cmd.comm  = COMM_TO_STOP;
              cmd.stand = STAND_START;
            end
          end else if (event_code == EV_COAST_TIMEOUT) begin
            cmd.coast = COAST_OVER;
          end
        end
        MODE_FULL: begin
          if (event_code == EV_IGN_OFF) begin
            cmd.comm = COMM_TX_STOP;
            cmd.ign  = IGN_END;
            cmd.diag = DIAG_STOP;
          end else if (event_code == EV_COMM_TIMEOUT) begin
            cmd.coast = COAST_OVER;
            cmd.comm  = COMM_TX_STOP | COMM_TO_START;
            cmd.ign   = IGN_END;
            cmd.diag  = DIAG_STOP;
          end else if (event_code == EV_STOP) begin
            cmd.coast_load = 1'b1;
            cmd.coast      = COAST_START;
          end else if (event_code == EV_DRIVE) begin
            cmd.coast_clear = 1'b1;
            cmd.coast       = COAST_STOP;
          end else if (event_code == EV_COAST_TIMEOUT) begin
            cmd.coast = COAST_OVER;
          end
        end
        MODE_WAKE: begin
          if (event_code == EV_CAN_WAKE) begin
            cmd.stand = STAND_STOP;
            cmd.comm  = COMM_FULL | COMM_TO_START;
          end else if (event_code == EV_DEEPSTOP) begin
            cmd.comm = COMM_ALL_STOP;
            cmd.load_sleep = 1'b1;
          end else if (event_code == EV_SHUTDOWN) begin
            cmd.comm = COMM_ALL_STOP;
            cmd.load_shutdown = 1'b1;
          end
        end
        MODE_MONITOR: begin
          if (event_code == EV_CAN_WAKE) begin
            cmd.stand = STAND_STOP;
            cmd.comm  = COMM_TO_START;
          end else if (event_code == EV_DEEPSTOP) begin
            cmd.comm = COMM_NO_STANDBY | COMM_ALL_STOP;
            cmd.load_sleep = 1'b1;
          end else if (event_code == EV_SHUTDOWN) begin
            cmd.comm = COMM_ALL_STOP;
            cmd.load_shutdown = 1'b1;
          end else if (event_code == EV_COAST_TIMEOUT) begin
            cmd.coast = COAST_OVER;
          end
        end
        default: ;
      endcase
    end
  end

  assign mode_now = mode_reg_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg <= MODE_OFF;
    end else begin
      mode_reg <= mode_reg_next;
    end
  end

`ifndef SYNTH
  a_off_quiet: assert property (@(posedge clk) disable iff (rst)
    tick && mode_reg == MODE_OFF |-> cmd == '0) else $error("command in off mode");
  a_load_off: assert property (@(posedge clk) disable iff (rst)
    cmd.load_shutdown || cmd.load_sleep |=> mode_reg == MODE_OFF)
    else $error("countdown load without off mode");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(mode_reg)) else $error("mode changed while idle");
`endif

endmodule

// ===== src/ecu_power_mode_sequencer_top.sv =====
// Top level of the ECU power-mode sequencer: handshake, registers, result stage.
//
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  s_tuser opcode, s_tdata event/timeout/mode
//  m_*      out  m_tvalid/m_tready  m_tdata result status
//  apb      in   psel/penable       paddr, pwdata, prdata (three registers)
//
// One item per cycle while m_tready allows; input register, then result register.
// Each item is applied to the state in the cycle it leaves the input register.
// Reset is synchronous; no clearing pass.
// With m_tready low the result holds, one more item waits in the input register,
// then s_tready drops.
module ecu_power_mode_sequencer_top import epms_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,  // event_code[3:0], timeout[19:4], new_mode[22:20]
  input  logic [2:0]  s_tuser,  // opcode[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  // mode_now[2:0], power_action[5:3], shutdown_target[6], reset_kind[8:7],
  // comm_actions[15:9], coast_signal[17:16], ignition_cycle[19:18],
  // diag_monitoring[21:20], standstill_action[23:22], comm_tick[24],
  // event_dropped[25]
  output logic [31:0] m_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic        in_valid;
  logic [2:0]  opcode;
  logic [3:0]  event_code;
  logic [15:0] timeout;
  logic [2:0]  new_mode;
  logic        advance;

  logic [15:0] reset_min_delay;
  logic [31:0] coast_time;
  logic        no_standstill_mode;

  logic [2:0]  action;
  logic        coast_expire;
  logic        target_now;
  logic [1:0]  rtype_now;
  logic [2:0]  mode_now;
  cmd_t        cmd;
  logic [3:0]  front;
  logic        dropped;
  logic        is_tick;
  logic        post;
  logic [31:0] result_next;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;
  assign is_tick  = advance && (opcode == OP_TICK);
  assign post     = advance && (opcode == OP_POST) && (event_code != EV_NONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tvalid && s_tready) begin
      opcode     <= s_tuser;
      event_code <= s_tdata[3:0];
      timeout    <= s_tdata[19:4];
      new_mode   <= s_tdata[22:20];
    end
  end

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      reset_min_delay    <= RESET_MIN_DELAY_DEF;
      coast_time         <= COAST_TIME_DEF;
      no_standstill_mode <= 1'b0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_RESET_MIN_DELAY: reset_min_delay    <= pwdata[15:0];
        REG_COAST_TIME:      coast_time         <= pwdata;
        REG_NO_STANDSTILL:   no_standstill_mode <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_RESET_MIN_DELAY: prdata = {16'd0, reset_min_delay};
      REG_COAST_TIME:      prdata = coast_time;
      REG_NO_STANDSTILL:   prdata = {31'd0, no_standstill_mode};
      default:             prdata = '0;
    endcase
  end

  epms_timers u_timers (
    .clk             (clk),
    .rst             (rst),
    .en              (advance),
    .op              (opcode),
    .timeout         (timeout),
    .reset_min_delay (reset_min_delay),
    .coast_time      (coast_time),
    .cmd             (cmd),
    .action          (action),
    .coast_expire    (coast_expire),
    .target_now      (target_now),
    .rtype_now       (rtype_now)
  );

  epms_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_en   (post || coast_expire),
    .push_code (post ? event_code : EV_COAST_TIMEOUT),
    .pop_en    (is_tick),
    .front     (front),
    .dropped   (dropped)
  );

  epms_mode_fsm u_fsm (
    .clk           (clk),
    .rst           (rst),
    .en            (advance),
    .op            (opcode),
    .new_mode      (new_mode),
    .event_code    (front),
    .no_standstill (no_standstill_mode),
    .mode_now      (mode_now),
    .cmd           (cmd)
  );

  assign result_next = {6'd0, dropped, is_tick, cmd.stand, cmd.diag, cmd.ign,
                        cmd.coast, cmd.comm, rtype_now, target_now, action, mode_now};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (advance) begin
      m_tdata <= result_next;
    end
  end

`ifndef SYNTH
  a_advance_out: assert property (@(posedge clk) disable iff (rst)
    advance |=> m_tvalid) else $error("result lost");
  a_action_tick: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[5:3] != ACT_NONE |-> m_tdata[24])
    else $error("power action without tick");
  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !in_valid |-> s_tready) else $error("ready low with empty input stage");
  a_hold_input: assert property (@(posedge clk) disable iff (rst)
    in_valid && !advance |=> in_valid && $stable(opcode) && $stable(timeout))
    else $error("waiting item changed");
`endif

endmodule

// ===== test/ecu_power_mode_sequencer_top_tb.sv =====
// Self-checking testbench of the ECU power-mode sequencer top level.
module ecu_power_mode_sequencer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import epms_pkg::*;

  localparam logic [2:0] OP_SPARE_LO  = 3'd6;
  localparam logic [2:0] OP_SPARE_HI  = 3'd7;
  localparam logic [3:0] EV_UNKNOWN   = 4'd12;
  localparam logic [3:0] EV_TOP_CODE  = 4'd15;
  localparam logic [2:0] MODE_BAD_TOP = 3'd7;
  localparam int PIPE_LATENCY = 2;
  localparam int SETTLE_LIMIT = 5000;
  localparam int LONG_HOLD    = 80;

  typedef struct packed {
    logic [5:0] pad;
    logic       event_dropped;
    logic       comm_tick;
    logic [1:0] standstill_action;
    logic [1:0] diag_monitoring;
    logic [1:0] ignition_cycle;
    logic [1:0] coast_signal;
    logic [6:0] comm_actions;
    logic [1:0] reset_kind;
    logic       shutdown_target;
    logic [2:0] power_action;
    logic [2:0] mode_now;
  } status_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;  // event_code[3:0], timeout[19:4], new_mode[22:20]
  logic [2:0]  s_tuser = '0;  // opcode[2:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;       // mode_now .. event_dropped, see status_t
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // predictor state
  logic [15:0] cfg_min_delay     = RESET_MIN_DELAY_DEF;
  logic [31:0] cfg_coast_time    = COAST_TIME_DEF;
  logic        cfg_no_standstill = 1'b0;
  mode_t       cur_mode          = MODE_OFF;
  logic [3:0]  queued_events[$];
  logic [15:0] cnt_shutdown = '0, cnt_sleep = '0, cnt_reset = '0;
  logic [15:0] cnt_boot = '0, cnt_tester = '0;
  logic [31:0] cnt_coast = '0;
  logic        target_now = TARGET_OFF;
  logic [1:0]  reset_kind_now = RST_PLAIN;

  status_t pending_status[$];
  int      errors = 0;
  int      results_seen = 0;
  int      tx_burst = 0;
  int      rx_burst = 0;
  bit      rx_hold_pending = 1'b0;

  ecu_power_mode_sequencer_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string what);
    if (errors < 40) begin
      $display("mismatch at %0t: %s", $realtime, what);
    end
    errors++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) begin
      report_mismatch($sformatf("result %0d %s got %0d want %0d", results_seen, name, got, want));
    end
  endtask

  function automatic int draw_gap(inout int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      burst = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 12);
  endfunction

  function automatic logic [15:0] armed(input logic [15:0] ticks);
    return (ticks < cfg_min_delay) ? cfg_min_delay : ticks;
  endfunction

  task automatic predict_status(input logic [2:0] op, input logic [3:0] ev_in,
                                input logic [15:0] ticks, input logic [2:0] nm,
                                output status_t st);
    logic [3:0] ev;
    st = '0;
    case (op)
      OP_POST: begin
        if (ev_in != EV_NONE) begin
          if (queued_events.size() >= QUEUE_DEPTH_DEF) st.event_dropped = 1'b1;
          else queued_events.push_back(ev_in);
        end
      end
      OP_ARM_RESET:  cnt_reset  = armed(ticks);
      OP_ARM_BOOT:   cnt_boot   = armed(ticks);
      OP_ARM_TESTER: cnt_tester = armed(ticks);
      OP_FORCE_MODE: begin
        if (nm <= MODE_MAX) cur_mode = mode_t'(nm);
      end
      OP_TICK: begin
        if (cnt_shutdown != 0) begin
          cnt_shutdown = cnt_shutdown - 1'b1;
          if (cnt_shutdown == 0) begin
            st.power_action = ACT_SHUTDOWN;
            target_now = TARGET_OFF;
          end
        end else if (cnt_sleep != 0) begin
          cnt_sleep = cnt_sleep - 1'b1;
          if (cnt_sleep == 0) begin
            st.power_action = ACT_SLEEP;
            target_now = TARGET_SLEEP;
          end
        end else if (cnt_reset != 0) begin
          cnt_reset = cnt_reset - 1'b1;
          if (cnt_reset == 0) begin
            st.power_action = ACT_RESET;
            reset_kind_now = RST_PLAIN;
          end
        end else if (cnt_boot != 0) begin
          cnt_boot = cnt_boot - 1'b1;
          if (cnt_boot == 0) begin
            st.power_action = ACT_BOOT;
            reset_kind_now = RST_BOOT;
          end
        end else if (cnt_tester != 0) begin
          cnt_tester = cnt_tester - 1'b1;
          if (cnt_tester == 0) begin
            st.power_action = ACT_TESTER;
            reset_kind_now = RST_TESTER;
          end
        end else if (cnt_coast != 0) begin
          cnt_coast = cnt_coast - 1'b1;
          if (cnt_coast == 0) begin
            if (queued_events.size() >= QUEUE_DEPTH_DEF) st.event_dropped = 1'b1;
            else queued_events.push_back(EV_COAST_TIMEOUT);
          end
        end
        st.comm_tick = 1'b1;
        if (queued_events.size() != 0) begin
          ev = queued_events.pop_front();
          case (cur_mode)
            MODE_QUIET: begin
              case (ev)
                EV_IGN_ON: begin
                  st.comm_actions = COMM_TX_START | COMM_TO_START;
                  st.diag_monitoring = DIAG_START;
                  st.ignition_cycle = IGN_START;
                  if (!cfg_no_standstill) st.standstill_action = STAND_FORWARD;
                  cur_mode = MODE_FULL;
                end
                EV_COMM_TIMEOUT: begin
                  st.comm_actions = COMM_TO_STOP;
                  if (cfg_no_standstill) begin
                    st.comm_actions |= COMM_ALL_STOP;
                    cnt_shutdown = MACHINE_DELAY;
                    cur_mode = MODE_OFF;
                  end else begin
                    st.standstill_action = STAND_START;
                    cur_mode = MODE_MONITOR;
                  end
                end
                EV_COAST_TIMEOUT: st.coast_signal = COAST_OVER;
                default: ;
              endcase
            end
            MODE_FULL: begin
              case (ev)
                EV_IGN_OFF: begin
                  st.comm_actions = COMM_TX_STOP;
                  st.ignition_cycle = IGN_END;
                  st.diag_monitoring = DIAG_STOP;
                  cur_mode = MODE_QUIET;
                end
                EV_COMM_TIMEOUT: begin
                  st.coast_signal = COAST_OVER;
                  st.comm_actions = COMM_TX_STOP | COMM_TO_START;
                  st.ignition_cycle = IGN_END;
                  st.diag_monitoring = DIAG_STOP;
                  cur_mode = MODE_QUIET;
                end
                EV_STOP: begin
                  cnt_coast = cfg_coast_time;
                  st.coast_signal = COAST_START;
                end
                EV_DRIVE: begin
                  cnt_coast = '0;
                  st.coast_signal = COAST_STOP;
                end
                EV_COAST_TIMEOUT: st.coast_signal = COAST_OVER;
                default: ;
              endcase
            end
            MODE_WAKE: begin
              case (ev)
                EV_CAN_WAKE: begin
                  st.standstill_action = STAND_STOP;
                  st.comm_actions = COMM_FULL | COMM_TO_START;
                  cur_mode = MODE_QUIET;
                end
                EV_DEEPSTOP: begin
                  st.comm_actions = COMM_ALL_STOP;
                  cnt_sleep = MACHINE_DELAY;
                  cur_mode = MODE_OFF;
                end
                EV_SHUTDOWN: begin
                  st.comm_actions = COMM_ALL_STOP;
                  cnt_shutdown = MACHINE_DELAY;
                  cur_mode = MODE_OFF;
                end
                default: ;
              endcase
            end
            MODE_MONITOR: begin
              case (ev)
                EV_CAN_WAKE: begin
                  st.standstill_action = STAND_STOP;
                  st.comm_actions = COMM_TO_START;
                  cur_mode = MODE_QUIET;
                end
                EV_DEEPSTOP: begin
                  st.comm_actions = COMM_NO_STANDBY | COMM_ALL_STOP;
                  cnt_sleep = MACHINE_DELAY;
                  cur_mode = MODE_OFF;
                end
                EV_SHUTDOWN: begin
                  st.comm_actions = COMM_ALL_STOP;
                  cnt_shutdown = MACHINE_DELAY;
                  cur_mode = MODE_OFF;
                end
                EV_COAST_TIMEOUT: st.coast_signal = COAST_OVER;
                default: ;
              endcase
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase
    st.mode_now = cur_mode;
    st.shutdown_target = target_now;
    st.reset_kind = reset_kind_now;
  endtask

  // Leaves s_tvalid high when the next transaction follows without a gap.
  task automatic send_item(input logic [2:0] op, input logic [3:0] ev,
                           input logic [15:0] ticks, input logic [2:0] nm);
    status_t st;
    int gap;
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {1'b0, nm, ticks, ev};
    do @(posedge clk); while (!s_tready);
    predict_status(op, ev, ticks, nm, st);
    pending_status.push_back(st);
    gap = draw_gap(tx_burst);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic settle();
    int waited;
    waited = 0;
    s_tvalid <= 1'b0;
    while (pending_status.size() != 0 && waited < SETTLE_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending_status.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", pending_status.size()));
      pending_status.delete();
    end
    repeat (PIPE_LATENCY + 3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_RESET_MIN_DELAY: cfg_min_delay = value[15:0];
      REG_COAST_TIME:      cfg_coast_time = value;
      REG_NO_STANDSTILL:   cfg_no_standstill = value[0];
      default: ;
    endcase
  endtask

  function automatic logic [3:0] pick_event();
    if ($urandom_range(0, 99) < 85) return 4'($urandom_range(EV_IGN_ON, EV_SHUTDOWN));
    return 4'($urandom_range(0, EV_TOP_CODE));
  endfunction

  function automatic logic [15:0] pick_ticks();
    if ($urandom_range(0, 9) == 0) return 16'($urandom_range(0, 16'hFFFF));
    return 16'($urandom_range(0, 24));
  endfunction

  task automatic run_random(input int count);
    int sent;
    int k;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 9) < 6) begin
        if ($urandom_range(0, 1)) begin
          send_item(OP_FORCE_MODE, pick_event(), pick_ticks(),
                    3'($urandom_range(MODE_QUIET, MODE_MAX)));
          sent++;
        end
        k = $urandom_range(1, 3);
        repeat (k) begin
          send_item(OP_POST, pick_event(), pick_ticks(), 3'($urandom_range(0, 7)));
          sent++;
        end
        k = $urandom_range(1, 4);
        repeat (k) begin
          send_item(OP_TICK, pick_event(), pick_ticks(), 3'($urandom_range(0, 7)));
          sent++;
        end
      end else begin
        send_item(3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)), pick_ticks(),
                  3'($urandom_range(0, 7)));
        sent++;
      end
    end
  endtask

  task automatic test_directed();
    send_item(OP_TICK, EV_NONE, 16'h0000, MODE_OFF);
    send_item(OP_POST, EV_NONE, 16'hFFFF, MODE_BAD_TOP);
    send_item(OP_POST, EV_TOP_CODE, 16'h0000, MODE_OFF);
    send_item(OP_TICK, EV_NONE, 16'h0000, MODE_OFF);
    send_item(OP_SPARE_LO, EV_TOP_CODE, 16'hFFFF, MODE_BAD_TOP);
    send_item(OP_SPARE_HI, EV_IGN_ON, 16'h0001, MODE_FULL);
    send_item(OP_FORCE_MODE, EV_NONE, 16'h0000, MODE_BAD_TOP);
    send_item(OP_FORCE_MODE, EV_NONE, 16'h0000, MODE_MONITOR);
    send_item(OP_POST, EV_SHUTDOWN, 16'h0000, MODE_OFF);
    send_item(OP_TICK, EV_NONE, 16'h0000, MODE_OFF);
    send_item(OP_ARM_RESET, EV_NONE, 16'h0000, MODE_OFF);
    send_item(OP_ARM_BOOT, EV_NONE, 16'hFFFF, MODE_OFF);
    send_item(OP_ARM_TESTER, EV_NONE, 16'h0005, MODE_OFF);
    // queue full: the fifth post is dropped
    send_item(OP_POST, EV_IGN_ON, 16'h0000, MODE_OFF);
    send_item(OP_POST, EV_IGN_OFF, 16'h0000, MODE_OFF);
    send_item(OP_POST, EV_COMM_TIMEOUT, 16'h0000, MODE_OFF);
    send_item(OP_POST, EV_STOP, 16'h0000, MODE_OFF);
    send_item(OP_POST, EV_DRIVE, 16'h0000, MODE_OFF);
    send_item(OP_TICK, EV_NONE, 16'h0000, MODE_OFF);
    send_item(OP_FORCE_MODE, EV_NONE, 16'h0000, MODE_OFF);
    settle();
  endtask

  task automatic test_countdowns();
    send_item(OP_ARM_BOOT, EV_NONE, 16'h0003, MODE_OFF);
    repeat (48) send_item(OP_TICK, EV_NONE, 16'h0000, MODE_OFF);
    settle();
  endtask

  task automatic test_mode_walk();
    logic [3:0] walk_events[10];
    walk_events = '{EV_IGN_ON, EV_IGN_OFF, EV_COMM_TIMEOUT, EV_STOP, EV_DRIVE,
                    EV_COAST_TIMEOUT, EV_CAN_WAKE, EV_DEEPSTOP, EV_SHUTDOWN, EV_UNKNOWN};
    for (int m = MODE_QUIET; m <= MODE_MAX; m++) begin
      foreach (walk_events[i]) begin
        send_item(OP_FORCE_MODE, EV_NONE, 16'h0000, 3'(m));
        send_item(OP_POST, walk_events[i], 16'h0000, MODE_OFF);
        send_item(OP_TICK, EV_NONE, 16'h0000, MODE_OFF);
      end
    end
    settle();
  endtask

  task automatic test_config_sweep();
    logic [15:0] min_set[5];
    logic [31:0] coast_set[5];
    logic        nostand_set[5];
    min_set     = '{16'd0, 16'hFFFF, 16'd3, 16'd10, 16'd0};
    coast_set   = '{32'd0, 32'hFFFF_FFFF, 32'd5, 32'd12, 32'd1};
    nostand_set = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b0};
    foreach (min_set[i]) begin
      write_reg(REG_RESET_MIN_DELAY, {16'h0, min_set[i]});
      write_reg(REG_COAST_TIME, coast_set[i]);
      write_reg(REG_NO_STANDSTILL, {31'h0, nostand_set[i]});
      send_item(OP_FORCE_MODE, EV_NONE, 16'h0000, MODE_FULL);
      send_item(OP_POST, EV_STOP, 16'h0000, MODE_OFF);
      repeat (3) send_item(OP_TICK, EV_NONE, 16'h0000, MODE_OFF);
      run_random(100);
      settle();
    end
  endtask

  task automatic test_backpressure();
    rx_hold_pending = 1'b1;
    run_random(40);
    settle();
  endtask

  task automatic test_random_bulk();
    write_reg(REG_RESET_MIN_DELAY, 32'd4);
    write_reg(REG_COAST_TIME, 32'd8);
    write_reg(REG_NO_STANDSTILL, 32'd0);
    run_random(320);
    settle();
    write_reg(REG_NO_STANDSTILL, 32'd1);
    run_random(320);
    settle();
  endtask

  initial begin : rx_side
    int n;
    @(posedge clk);
    forever begin
      if (rx_hold_pending) begin
        n = LONG_HOLD;
        rx_hold_pending = 1'b0;
      end else begin
        n = draw_gap(rx_burst);
      end
      if (n > 0) begin
        m_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && m_tready));
    end
  end

  always @(posedge clk) begin : check_result
    status_t got;
    status_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = status_t'(m_tdata);
      results_seen++;
      if (pending_status.size() == 0) begin
        report_mismatch($sformatf("result %0d with no transaction outstanding", results_seen));
      end else begin
        want = pending_status.pop_front();
        check_field("mode_now", got.mode_now, want.mode_now);
        check_field("power_action", got.power_action, want.power_action);
        check_field("shutdown_target", got.shutdown_target, want.shutdown_target);
        check_field("reset_kind", got.reset_kind, want.reset_kind);
        check_field("comm_actions", got.comm_actions, want.comm_actions);
        check_field("coast_signal", got.coast_signal, want.coast_signal);
        check_field("ignition_cycle", got.ignition_cycle, want.ignition_cycle);
        check_field("diag_monitoring", got.diag_monitoring, want.diag_monitoring);
        check_field("standstill_action", got.standstill_action, want.standstill_action);
        check_field("comm_tick", got.comm_tick, want.comm_tick);
        check_field("event_dropped", got.event_dropped, want.event_dropped);
        check_field("padding", got.pad, want.pad);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_countdowns();
    test_mode_walk();
    test_config_sweep();
    test_backpressure();
    test_random_bulk();
    settle();
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/epms_pkg.sv
src/epms_queue.sv
src/epms_timers.sv
src/epms_mode_fsm.sv
src/ecu_power_mode_sequencer_top.sv
test/ecu_power_mode_sequencer_top_tb.sv
